>>> hdl/smm_pkg.sv
`timescale 1ns / 1ps
// smm_pkg: widths, pipeline depths and register codes for the Shoup modular multiplier.
// No dependencies; used by smm_mul128 and shoup_modmul_128.
package smm_pkg;

   localparam int LIMB_W      = 64;
   localparam int WORD_W      = 2 * LIMB_W;   // one operand
   localparam int WIDE_W      = 3 * LIMB_W;   // low part kept for the correction
   localparam int PROD_W      = 4 * LIMB_W;   // full product
   localparam int DIG_W       = 32;           // multiplier digit
   localparam int DIGITS      = WORD_W / DIG_W;
   localparam int MUL_LATENCY = 4;            // stages in smm_mul128
   localparam int PIPE_DEPTH  = 2 * MUL_LATENCY + 2;
   localparam int NORM_W      = 6;
   localparam int ADDR_W      = 6;

   typedef enum logic [2:0] {
      REG_MODULUS_LOW  = 3'd0,
      REG_MODULUS_HIGH = 3'd1,
      REG_FIXED_LOW    = 3'd2,
      REG_FIXED_HIGH   = 3'd3,
      REG_PRECOMP_LOW  = 3'd4,
      REG_PRECOMP_HIGH = 3'd5,
      REG_NORM_SHIFT   = 3'd6
   } csr_index_type;

endpackage

>>> hdl/smm_mul128.sv
`timescale 1ns / 1ps
// smm_mul128: four-stage pipelined 128x128 -> 256 unsigned multiplier.
// Depends on smm_pkg for widths.
module smm_mul128 (
   input  logic                         clock,
   input  logic [smm_pkg::WORD_W-1:0]   x,
   input  logic [smm_pkg::WORD_W-1:0]   y,
   output logic [smm_pkg::PROD_W-1:0]   prod
);

   localparam int DW = smm_pkg::DIG_W;
   localparam int ND = smm_pkg::DIGITS;

   logic [2*DW-1:0]                       pp_in   [ND][ND];
   logic [2*DW-1:0]                       pp_ff   [ND][ND];
   logic [smm_pkg::WORD_W+DW-1:0]         row_in  [ND];
   logic [smm_pkg::WORD_W+DW-1:0]         row_ff  [ND];
   logic [smm_pkg::WIDE_W-1:0]            half_in [2];
   logic [smm_pkg::WIDE_W-1:0]            half_ff [2];
   logic [smm_pkg::PROD_W-1:0]            prod_in;
   logic [smm_pkg::PROD_W-1:0]            prod_ff;

   // stage 1: 32x32 digit products
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         for (int j = 0; j < ND; j++) begin
            pp_in[i][j] = x[i*DW +: DW] * y[j*DW +: DW];
         end
      end
   end

   // stage 2: one row per x digit; even and odd digit products do not overlap
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         row_in[i] = {{DW{1'b0}}, pp_ff[i][2], pp_ff[i][0]}
                   + {pp_ff[i][3], pp_ff[i][1], {DW{1'b0}}};
      end
   end

   // stage 3: pairs of rows
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         half_in[k] = {{DW{1'b0}}, row_ff[2*k]} + {row_ff[2*k+1], {DW{1'b0}}};
      end
   end

   // stage 4: final sum
   assign prod_in = {{smm_pkg::LIMB_W{1'b0}}, half_ff[0]}
                  + {half_ff[1], {smm_pkg::LIMB_W{1'b0}}};

   always_ff @(posedge clock) begin
      pp_ff   <= pp_in;
      row_ff  <= row_in;
      half_ff <= half_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hdl/shoup_modmul_128.sv
`timescale 1ns / 1ps
// shoup_modmul_128: top level, (a*b) mod d by Shoup's method with a fixed multiplicand.
// Depends on smm_pkg and smm_mul128.

// Usage: load the modulus d, the fixed multiplicand a and apre = floor(a*2^128/d)
// through the APB port while no item is in flight (64-bit registers at byte
// address 8*index). The block then takes one item per cycle: start is honored
// whenever busy is low, and busy is high only while reset is asserted. Each item
// returns exactly one result, rsp_strobe high for a single cycle, in order. The
// receiver cannot stall the block, so a result must be taken the cycle it
// appears. The pipeline is two chained 4-stage 128x128 multipliers (apre*b for
// the quotient estimate q, then q*d, with a*b running beside the first and
// delayed to meet q*d), one 192-bit subtract stage and one stage that compares
// against d and subtracts it. With a nonzero norm_shift the remainder is worked
// mod 2^128; with norm_shift zero the upper limb of the 192-bit difference acts
// as a borrow that forces the final subtract.
module shoup_modmul_128 (
   input  logic                          clock,
   input  logic                          reset,
   // item input
   input  logic                          start,
   output logic                          busy,
   input  logic [smm_pkg::LIMB_W-1:0]    req_operand_low,
   input  logic [smm_pkg::LIMB_W-1:0]    req_operand_high,
   // result output
   output logic                          rsp_strobe,
   output logic [smm_pkg::LIMB_W-1:0]    rsp_remainder_low,
   output logic [smm_pkg::LIMB_W-1:0]    rsp_remainder_high,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [smm_pkg::ADDR_W-1:0]    paddr,
   input  logic [smm_pkg::LIMB_W-1:0]    pwdata,
   output logic [smm_pkg::LIMB_W-1:0]    prdata,
   output logic                          pready
);

   localparam int LW = smm_pkg::LIMB_W;
   localparam int WW = smm_pkg::WORD_W;
   localparam int XW = smm_pkg::WIDE_W;
   localparam int PW = smm_pkg::PROD_W;
   localparam int ML = smm_pkg::MUL_LATENCY;
   localparam int PD = smm_pkg::PIPE_DEPTH;

   // ---------------------------------------------------------------- registers
   logic [LW-1:0]                modulus_low_ff,  modulus_low_in;
   logic [LW-1:0]                modulus_high_ff, modulus_high_in;
   logic [LW-1:0]                fixed_low_ff,    fixed_low_in;
   logic [LW-1:0]                fixed_high_ff,   fixed_high_in;
   logic [LW-1:0]                precomp_low_ff,  precomp_low_in;
   logic [LW-1:0]                precomp_high_ff, precomp_high_in;
   logic [smm_pkg::NORM_W-1:0]   norm_shift_ff,   norm_shift_in;

   logic                         csr_write;
   smm_pkg::csr_index_type       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = smm_pkg::csr_index_type'(paddr[smm_pkg::ADDR_W-1:3]);

   always_comb begin
      modulus_low_in  = modulus_low_ff;
      modulus_high_in = modulus_high_ff;
      fixed_low_in    = fixed_low_ff;
      fixed_high_in   = fixed_high_ff;
      precomp_low_in  = precomp_low_ff;
      precomp_high_in = precomp_high_ff;
      norm_shift_in   = norm_shift_ff;
      if (csr_write) begin
         case (csr_index)
            smm_pkg::REG_MODULUS_LOW:  modulus_low_in  = pwdata;
            smm_pkg::REG_MODULUS_HIGH: modulus_high_in = pwdata;
            smm_pkg::REG_FIXED_LOW:    fixed_low_in    = pwdata;
            smm_pkg::REG_FIXED_HIGH:   fixed_high_in   = pwdata;
            smm_pkg::REG_PRECOMP_LOW:  precomp_low_in  = pwdata;
            smm_pkg::REG_PRECOMP_HIGH: precomp_high_in = pwdata;
            smm_pkg::REG_NORM_SHIFT:   norm_shift_in   = pwdata[smm_pkg::NORM_W-1:0];
            default: ;                 // unmapped address, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_low_ff  <= LW'(1);
         modulus_high_ff <= '0;
         fixed_low_ff    <= '0;
         fixed_high_ff   <= '0;
         precomp_low_ff  <= '0;
         precomp_high_ff <= '0;
         norm_shift_ff   <= '0;
      end else begin
         modulus_low_ff  <= modulus_low_in;
         modulus_high_ff <= modulus_high_in;
         fixed_low_ff    <= fixed_low_in;
         fixed_high_ff   <= fixed_high_in;
         precomp_low_ff  <= precomp_low_in;
         precomp_high_ff <= precomp_high_in;
         norm_shift_ff   <= norm_shift_in;
      end
   end

   always_comb begin
      case (csr_index)
         smm_pkg::REG_MODULUS_LOW:  prdata = modulus_low_ff;
         smm_pkg::REG_MODULUS_HIGH: prdata = modulus_high_ff;
         smm_pkg::REG_FIXED_LOW:    prdata = fixed_low_ff;
         smm_pkg::REG_FIXED_HIGH:   prdata = fixed_high_ff;
         smm_pkg::REG_PRECOMP_LOW:  prdata = precomp_low_ff;
         smm_pkg::REG_PRECOMP_HIGH: prdata = precomp_high_ff;
         smm_pkg::REG_NORM_SHIFT:   prdata = {{(LW-smm_pkg::NORM_W){1'b0}}, norm_shift_ff};
         default:                   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   logic            accept;
   logic [PD-1:0]   vld_ff, vld_in;

   assign busy   = reset;   // the pipeline never backs up
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[PD-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- datapath
   logic [WW-1:0]   mod_d;
   logic [WW-1:0]   fix_a;
   logic [WW-1:0]   pre_a;
   logic [WW-1:0]   operand;
   logic [PW-1:0]   prod_q;
   logic [PW-1:0]   prod_ab;
   logic [PW-1:0]   prod_qd;

   assign mod_d   = {modulus_high_ff, modulus_low_ff};
   assign fix_a   = {fixed_high_ff, fixed_low_ff};
   assign pre_a   = {precomp_high_ff, precomp_low_ff};
   assign operand = {req_operand_high, req_operand_low};

   // quotient estimate: q = high half of apre*b
   smm_mul128 u_mul_q (
      .clock (clock),
      .x     (pre_a),
      .y     (operand),
      .prod  (prod_q)
   );

   smm_mul128 u_mul_ab (
      .clock (clock),
      .x     (fix_a),
      .y     (operand),
      .prod  (prod_ab)
   );

   smm_mul128 u_mul_qd (
      .clock (clock),
      .x     (prod_q[PW-1:WW]),
      .y     (mod_d),
      .prod  (prod_qd)
   );

   // a*b waits for q*d; only the low 192 bits matter
   logic [XW-1:0]   ab_dly_ff [ML];
   logic [XW-1:0]   ab_dly_in [ML];

   always_comb begin
      ab_dly_in[0] = prod_ab[XW-1:0];
      for (int k = 1; k < ML; k++) begin
         ab_dly_in[k] = ab_dly_ff[k-1];
      end
   end

   // r = a*b - q*d mod 2^192; top limb is the borrow limb
   logic [XW-1:0]   diff_ff, diff_in;

   assign diff_in = ab_dly_ff[ML-1] - prod_qd[XW-1:0];

   // correction: trial subtract of d, no borrow means r >= d
   logic [WW:0]     trial;
   logic            no_borrow;
   logic            wide_borrow;
   logic [WW-1:0]   rem_ff, rem_in;
   logic            take_ff, take_in;
   logic            ge_ff, ge_in;

   assign trial       = {1'b0, diff_ff[WW-1:0]} - {1'b0, mod_d};
   assign no_borrow   = ~trial[WW];
   assign wide_borrow = (norm_shift_ff == '0) && (diff_ff[XW-1:WW] != '0);
   assign take_in     = no_borrow | wide_borrow;
   assign ge_in       = no_borrow;
   assign rem_in      = take_in ? trial[WW-1:0] : diff_ff[WW-1:0];

   always_ff @(posedge clock) begin
      ab_dly_ff <= ab_dly_in;
      diff_ff   <= diff_in;
      rem_ff    <= rem_in;
      take_ff   <= take_in;
      ge_ff     <= ge_in;
   end

   assign rsp_strobe         = vld_ff[PD-1];
   assign rsp_remainder_low  = rem_ff[LW-1:0];
   assign rsp_remainder_high = rem_ff[WW-1:LW];

   // ---------------------------------------------------------------- checks
   logic [WW:0]     rem_plus_d;

   assign rem_plus_d = {1'b0, rem_ff} + {1'b0, mod_d};

   // every result belongs to an earlier accepted item
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PD))
      else $error("result without an item accepted %0d cycles earlier", PD);

   // without the final subtract the remainder is already below d
   a_no_sub_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !take_ff) |-> (rem_ff < mod_d))
      else $error("unreduced remainder left without correction");

   // a subtract taken on r >= d never wraps
   a_sub_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ge_ff) |-> !rem_plus_d[WW])
      else $error("correction on r >= d wrapped around");

endmodule
